// ===== rtl/core/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Shared widths, opcodes and the sideband record that rides the divider.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DATA_W = 32;   // operand / result part width
  localparam int LIN_W  = 33;   // add / sub / negate width
  localparam int PROD_W = 64;   // one 32x32 product
  localparam int SUM_W  = 65;   // sum of two products
  localparam int QUO_W  = 32;   // quotient bits produced by the divider

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_CONJ = 3'd4;
  localparam logic [2:0] OP_MOD  = 3'd5;

  // Everything besides the remainders that travels with a transaction
  // through the divider stages.
  typedef struct packed {
    logic              div_op;  // transaction is a divide
    logic              dz;      // divisor magnitude is zero
    logic              re_neg;  // real quotient is negative
    logic              im_neg;  // imaginary quotient is negative
    logic              re_big;  // real quotient is at least 2^32
    logic              im_big;  // imaginary quotient is at least 2^32
    logic [DATA_W-1:0] re;      // finished result of the other ops
    logic [DATA_W-1:0] im;
    logic              ov;
  } cau_side_t;

endpackage

// ===== rtl/core/cau_in_if.sv =====
// ----------------------------------------------------------------------------
// cau_in_if
// Operand channel: opcode and two complex operands with valid/ready.
// ----------------------------------------------------------------------------
interface cau_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic signed [31:0] left_re;
  logic signed [31:0] left_im;
  logic signed [31:0] right_re;
  logic signed [31:0] right_im;

  modport source (output valid, output op, output left_re, output left_im,
                  output right_re, output right_im, input ready);
  modport sink   (input valid, input op, input left_re, input left_im,
                  input right_re, input right_im, output ready);
endinterface

// ===== rtl/core/cau_out_if.sv =====
// ----------------------------------------------------------------------------
// cau_out_if
// Result channel: complex result and status flags with valid/ready.
// ----------------------------------------------------------------------------
interface cau_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_re;
  logic signed [31:0] res_im;
  logic               overflow;
  logic               div_zero;

  modport source (output valid, output res_re, output res_im, output overflow,
                  output div_zero, input ready);
  modport sink   (input valid, input res_re, input res_im, input overflow,
                  input div_zero, output ready);
endinterface

// ===== rtl/core/cau_div_pipe.sv =====
// ----------------------------------------------------------------------------
// cau_div_pipe
// Restoring divider, one quotient bit per stage, two lanes sharing a divisor.
// ----------------------------------------------------------------------------
module cau_div_pipe (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  cau_pkg::cau_side_t              in_side,
  input  logic [cau_pkg::PROD_W-1:0]      in_den,
  input  logic [cau_pkg::PROD_W-1:0]      in_rem_re,
  input  logic [cau_pkg::QUO_W-1:0]       in_qn_re,
  input  logic [cau_pkg::PROD_W-1:0]      in_rem_im,
  input  logic [cau_pkg::QUO_W-1:0]       in_qn_im,
  output logic                            out_valid,
  output cau_pkg::cau_side_t              out_side,
  output logic [cau_pkg::QUO_W-1:0]       out_q_re,
  output logic [cau_pkg::QUO_W-1:0]       out_q_im
);
  import cau_pkg::*;

  logic [QUO_W-1:0] v_r;
  logic [QUO_W-1:0] v_nxt;
  logic [QUO_W-1:0] adv;
  cau_side_t        side_r   [QUO_W];
  logic [PROD_W-1:0] den_r   [QUO_W];
  logic [PROD_W-1:0] rem_re_r [QUO_W];
  logic [PROD_W-1:0] rem_im_r [QUO_W];
  logic [QUO_W-1:0]  qn_re_r  [QUO_W];
  logic [QUO_W-1:0]  qn_im_r  [QUO_W];

  logic              src_v      [QUO_W];
  cau_side_t         src_side   [QUO_W];
  logic [PROD_W-1:0] src_den    [QUO_W];
  logic [PROD_W-1:0] src_rem_re [QUO_W];
  logic [PROD_W-1:0] src_rem_im [QUO_W];
  logic [QUO_W-1:0]  src_qn_re  [QUO_W];
  logic [QUO_W-1:0]  src_qn_im  [QUO_W];
  logic [PROD_W-1:0] sh_re      [QUO_W];
  logic [PROD_W-1:0] sh_im      [QUO_W];
  logic              ge_re      [QUO_W];
  logic              ge_im      [QUO_W];
  logic [PROD_W-1:0] rem_re_nxt [QUO_W];
  logic [PROD_W-1:0] rem_im_nxt [QUO_W];
  logic [QUO_W-1:0]  qn_re_nxt  [QUO_W];
  logic [QUO_W-1:0]  qn_im_nxt  [QUO_W];

  always_comb begin
    for (int k = 0; k < QUO_W; k++) begin
      if (k == 0) begin
        src_v[k]      = in_valid;
        src_side[k]   = in_side;
        src_den[k]    = in_den;
        src_rem_re[k] = in_rem_re;
        src_rem_im[k] = in_rem_im;
        src_qn_re[k]  = in_qn_re;
        src_qn_im[k]  = in_qn_im;
      end else begin
        src_v[k]      = v_r[k-1];
        src_side[k]   = side_r[k-1];
        src_den[k]    = den_r[k-1];
        src_rem_re[k] = rem_re_r[k-1];
        src_rem_im[k] = rem_im_r[k-1];
        src_qn_re[k]  = qn_re_r[k-1];
        src_qn_im[k]  = qn_im_r[k-1];
      end
      // shift in the next dividend bit, subtract when the divisor fits
      sh_re[k]      = {src_rem_re[k][PROD_W-2:0], src_qn_re[k][QUO_W-1]};
      sh_im[k]      = {src_rem_im[k][PROD_W-2:0], src_qn_im[k][QUO_W-1]};
      ge_re[k]      = sh_re[k] >= src_den[k];
      ge_im[k]      = sh_im[k] >= src_den[k];
      rem_re_nxt[k] = ge_re[k] ? sh_re[k] - src_den[k] : sh_re[k];
      rem_im_nxt[k] = ge_im[k] ? sh_im[k] - src_den[k] : sh_im[k];
      qn_re_nxt[k]  = {src_qn_re[k][QUO_W-2:0], ge_re[k]};
      qn_im_nxt[k]  = {src_qn_im[k][QUO_W-2:0], ge_im[k]};
      // a stage loads when it is empty or the output side drains
      adv[k]        = en | !v_r[k];
    end
    for (int k = 0; k < QUO_W; k++) begin
      if (adv[k]) begin
        v_nxt[k] = src_v[k];
      end else if (k == QUO_W-1) begin
        v_nxt[k] = !en;
      end else begin
        v_nxt[k] = !adv[k+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QUO_W; k++) begin
      if (adv[k]) begin
        side_r[k]   <= src_side[k];
        den_r[k]    <= src_den[k];
        rem_re_r[k] <= rem_re_nxt[k];
        rem_im_r[k] <= rem_im_nxt[k];
        qn_re_r[k]  <= qn_re_nxt[k];
        qn_im_r[k]  <= qn_im_nxt[k];
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[QUO_W-1];
  assign out_side  = side_r[QUO_W-1];
  assign out_q_re  = qn_re_r[QUO_W-1];
  assign out_q_im  = qn_im_r[QUO_W-1];

endmodule

// ===== rtl/core/complex_arithmetic_unit_top.sv =====
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_top
// Complex ALU in signed fixed point: add, sub, mul, div, conj, |L|^2.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle unless the output stalls; each opcode
//   goes through the 32-stage bit-per-stage divider to keep results in order.
// Empty stages keep filling while the result waits, so input is taken until
//   the pipeline is full.
// Reset: synchronous, active low; clears all stage valid bits, no data reset.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  cau_in_if.sink    in_chan,
  cau_out_if.source out_chan
);
  import cau_pkg::*;

  localparam int SH = DATA_W - FRAC_BITS;
  localparam logic [DATA_W-1:0]       MAX32  = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0]       MIN32  = 32'h8000_0000;
  localparam logic signed [SUM_W-1:0] SAT_HI = 65'sd2147483647;
  localparam logic signed [SUM_W-1:0] SAT_LO = -65'sd2147483648;

  typedef struct packed {
    logic              ov;
    logic [DATA_W-1:0] val;
  } sat_t;

  // clamp a wide signed value into 32 bits
  function automatic sat_t sat65(input logic signed [SUM_W-1:0] v);
    sat_t s;
    if (v > SAT_HI) begin
      s = '{ov: 1'b1, val: MAX32};
    end else if (v < SAT_LO) begin
      s = '{ov: 1'b1, val: MIN32};
    end else begin
      s = '{ov: 1'b0, val: v[DATA_W-1:0]};
    end
    return s;
  endfunction

  // apply sign to an unsigned quotient and clamp
  function automatic sat_t div_sat(input logic neg, input logic big,
                                   input logic [QUO_W-1:0] q);
    sat_t s;
    if (big) begin
      s = '{ov: 1'b1, val: (neg ? MIN32 : MAX32)};
    end else if (neg) begin
      if (q > MIN32) begin
        s = '{ov: 1'b1, val: MIN32};
      end else begin
        s = '{ov: 1'b0, val: DATA_W'(~q + 1'b1)};
      end
    end else if (q > MAX32) begin
      s = '{ov: 1'b1, val: MAX32};
    end else begin
      s = '{ov: 1'b0, val: q};
    end
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Global drain: the output register empties or is taken this cycle. Every
  // stage loads when it is empty or when everything downstream advances.
  // --------------------------------------------------------------------------
  logic en;
  logic out_valid_r;
  assign en = out_chan.ready | !out_valid_r;

  // --------------------------------------------------------------------------
  // Stage 1: six products plus the linear ops (add, sub, negate).
  // --------------------------------------------------------------------------
  logic                     s1_v_r;
  logic                     s1_adv;
  logic [2:0]               s1_op_r;
  logic signed [PROD_W-1:0] s1_p_r   [6];
  logic signed [PROD_W-1:0] s1_p_nxt [6];
  logic signed [LIN_W-1:0]  s1_lin_re_r, s1_lin_re_nxt;
  logic signed [LIN_W-1:0]  s1_lin_im_r, s1_lin_im_nxt;
  logic signed [DATA_W-1:0] opa, opb, opc, opd, mb0, mb1;

  assign s1_adv        = en | !s1_v_r;
  assign in_chan.ready = s1_adv;

  always_comb begin
    opa = in_chan.left_re;
    opb = in_chan.left_im;
    opc = in_chan.right_re;
    opd = in_chan.right_im;
    // modulus squares the left operand on the first two multipliers
    mb0 = (in_chan.op == OP_MOD) ? opa : opc;
    mb1 = (in_chan.op == OP_MOD) ? opb : opd;
    s1_p_nxt[0] = opa * mb0;
    s1_p_nxt[1] = opb * mb1;
    s1_p_nxt[2] = opb * opc;
    s1_p_nxt[3] = opa * opd;
    s1_p_nxt[4] = opc * opc;
    s1_p_nxt[5] = opd * opd;
    case (in_chan.op)
      OP_ADD: begin
        s1_lin_re_nxt = LIN_W'(opa) + LIN_W'(opc);
        s1_lin_im_nxt = LIN_W'(opb) + LIN_W'(opd);
      end
      OP_SUB: begin
        s1_lin_re_nxt = LIN_W'(opa) - LIN_W'(opc);
        s1_lin_im_nxt = LIN_W'(opb) - LIN_W'(opd);
      end
      OP_CONJ: begin
        s1_lin_re_nxt = LIN_W'(opa);
        s1_lin_im_nxt = -LIN_W'(opb);
      end
      default: begin
        s1_lin_re_nxt = '0;
        s1_lin_im_nxt = '0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage 2: product sums and the divisor magnitude c^2 + d^2.
  // --------------------------------------------------------------------------
  logic                     s2_v_r;
  logic                     s2_adv;
  logic [2:0]               s2_op_r;
  logic signed [SUM_W-1:0]  s2_re_r, s2_re_nxt;
  logic signed [SUM_W-1:0]  s2_im_r, s2_im_nxt;
  logic [PROD_W-1:0]        s2_den_r, s2_den_nxt;

  assign s2_adv = en | !s2_v_r;

  always_comb begin
    s2_den_nxt = PROD_W'(s1_p_r[4]) + PROD_W'(s1_p_r[5]);
    case (s1_op_r)
      OP_MUL: begin
        s2_re_nxt = SUM_W'(s1_p_r[0]) - SUM_W'(s1_p_r[1]);
        s2_im_nxt = SUM_W'(s1_p_r[2]) + SUM_W'(s1_p_r[3]);
      end
      OP_DIV: begin
        s2_re_nxt = SUM_W'(s1_p_r[0]) + SUM_W'(s1_p_r[1]);
        s2_im_nxt = SUM_W'(s1_p_r[2]) - SUM_W'(s1_p_r[3]);
      end
      OP_MOD: begin
        s2_re_nxt = SUM_W'(s1_p_r[0]) + SUM_W'(s1_p_r[1]);
        s2_im_nxt = '0;
      end
      default: begin
        s2_re_nxt = SUM_W'(s1_lin_re_r);
        s2_im_nxt = SUM_W'(s1_lin_im_r);
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage 3: finish the non-divide ops (scale, clamp); set up the dividend
  // for the divider as |num| << FRAC_BITS, with the top part already in the
  // remainder. A top part not below the divisor means a quotient >= 2^32.
  // --------------------------------------------------------------------------
  logic                         s3_v_r;
  logic                         s3_adv;
  cau_side_t                    s3_side_r, s3_side_nxt;
  logic [PROD_W-1:0]            s3_den_r;
  logic [PROD_W-1:0]            s3_rem_re_r, s3_rem_im_r, rem0_re, rem0_im;
  logic [QUO_W-1:0]             s3_qn_re_r, s3_qn_im_r;
  logic [PROD_W-1:0]            mag_re, mag_im;
  logic [PROD_W+FRAC_BITS-1:0]  nw_re, nw_im;
  logic signed [SUM_W-1:0]      sc_re, sc_im;
  sat_t                         st_re, st_im;
  logic                         dp_ready;

  assign s3_adv = (en | !s3_v_r);

  always_comb begin
    if ((s2_op_r == OP_MUL) || (s2_op_r == OP_MOD)) begin
      sc_re = s2_re_r >>> FRAC_BITS;
      sc_im = s2_im_r >>> FRAC_BITS;
    end else begin
      sc_re = s2_re_r;
      sc_im = s2_im_r;
    end
    st_re = sat65(sc_re);
    st_im = sat65(sc_im);

    mag_re  = s2_re_r[SUM_W-1] ? PROD_W'(-s2_re_r) : PROD_W'(s2_re_r);
    mag_im  = s2_im_r[SUM_W-1] ? PROD_W'(-s2_im_r) : PROD_W'(s2_im_r);
    nw_re   = {mag_re, {FRAC_BITS{1'b0}}};
    nw_im   = {mag_im, {FRAC_BITS{1'b0}}};
    rem0_re = mag_re >> SH;
    rem0_im = mag_im >> SH;

    s3_side_nxt.div_op = (s2_op_r == OP_DIV);
    s3_side_nxt.dz     = (s2_den_r == '0);
    s3_side_nxt.re_neg = s2_re_r[SUM_W-1];
    s3_side_nxt.im_neg = s2_im_r[SUM_W-1];
    s3_side_nxt.re_big = (rem0_re >= s2_den_r);
    s3_side_nxt.im_big = (rem0_im >= s2_den_r);
    case (s2_op_r) inside
      OP_ADD, OP_SUB, OP_MUL, OP_CONJ, OP_MOD: begin
        s3_side_nxt.re = st_re.val;
        s3_side_nxt.im = st_im.val;
        s3_side_nxt.ov = st_re.ov | st_im.ov;
      end
      default: begin
        s3_side_nxt.re = '0;
        s3_side_nxt.im = '0;
        s3_side_nxt.ov = 1'b0;
      end
    endcase
  end

  // stage valid bits: load on advance, drop when the next stage takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
    end else begin
      s1_v_r <= s1_adv ? in_chan.valid : !s2_adv;
      s2_v_r <= s2_adv ? s1_v_r : !s3_adv;
      s3_v_r <= s3_adv ? s2_v_r : !dp_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_op_r     <= in_chan.op;
      s1_p_r      <= s1_p_nxt;
      s1_lin_re_r <= s1_lin_re_nxt;
      s1_lin_im_r <= s1_lin_im_nxt;
    end
    if (s2_adv) begin
      s2_op_r  <= s1_op_r;
      s2_re_r  <= s2_re_nxt;
      s2_im_r  <= s2_im_nxt;
      s2_den_r <= s2_den_nxt;
    end
    if (s3_adv) begin
      s3_side_r   <= s3_side_nxt;
      s3_den_r    <= s2_den_r;
      s3_rem_re_r <= rem0_re;
      s3_rem_im_r <= rem0_im;
      s3_qn_re_r  <= nw_re[QUO_W-1:0];
      s3_qn_im_r  <= nw_im[QUO_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stages 4-35: divider, one quotient bit per stage per lane.
  // --------------------------------------------------------------------------
  logic             dp_out_valid;
  cau_side_t        dp_side;
  logic [QUO_W-1:0] dp_q_re, dp_q_im;

  cau_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_v_r),
    .in_ready  (dp_ready),
    .in_side   (s3_side_r),
    .in_den    (s3_den_r),
    .in_rem_re (s3_rem_re_r),
    .in_qn_re  (s3_qn_re_r),
    .in_rem_im (s3_rem_im_r),
    .in_qn_im  (s3_qn_im_r),
    .out_valid (dp_out_valid),
    .out_side  (dp_side),
    .out_q_re  (dp_q_re),
    .out_q_im  (dp_q_im)
  );

  // --------------------------------------------------------------------------
  // Stage 36: output register. Divide result (zeros if dz) or the carried one.
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0] res_re_r, res_re_nxt;
  logic [DATA_W-1:0] res_im_r, res_im_nxt;
  logic              ov_r, ov_nxt;
  logic              dz_r, dz_nxt;
  sat_t              dq_re, dq_im;

  always_comb begin
    dq_re = div_sat(dp_side.re_neg, dp_side.re_big, dp_q_re);
    dq_im = div_sat(dp_side.im_neg, dp_side.im_big, dp_q_im);
    if (!dp_side.div_op) begin
      res_re_nxt = dp_side.re;
      res_im_nxt = dp_side.im;
      ov_nxt     = dp_side.ov;
      dz_nxt     = 1'b0;
    end else if (dp_side.dz) begin
      res_re_nxt = '0;
      res_im_nxt = '0;
      ov_nxt     = 1'b0;
      dz_nxt     = 1'b1;
    end else begin
      res_re_nxt = dq_re.val;
      res_im_nxt = dq_im.val;
      ov_nxt     = dq_re.ov | dq_im.ov;
      dz_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dp_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_re_r <= res_re_nxt;
      res_im_r <= res_im_nxt;
      ov_r     <= ov_nxt;
      dz_r     <= dz_nxt;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.res_re   = res_re_r;
  assign out_chan.res_im   = res_im_r;
  assign out_chan.overflow = ov_r;
  assign out_chan.div_zero = dz_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && dz_r) |-> (res_re_r == '0 && res_im_r == '0 && !ov_r))
    else $error("divide by zero result not cleared");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(ov_r && dz_r))
    else $error("overflow and divide by zero both set");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> s1_v_r)
    else $error("accepted transaction not captured in stage 1");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("output valid after reset");

endmodule
